@@ hw/rtl/swt_pkg.sv @@
// Package for the sorted unique word table: beat types, status codes and defaults.
// Used by the core RTL file; depends on nothing.
`default_nettype none
package swt_pkg;

    // Default sizes of the table.
    localparam int ENTRIES_DEF    = 128;
    localparam int WORD_CHARS_DEF = 64;

    // Status codes of a result beat.
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_PERIOD   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_READ     = 3'd4;
    localparam logic [2:0] ST_BADIDX   = 3'd5;

    // Operation codes of an input beat.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [7:0] CHAR_PERIOD = 8'h2E;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic       last_char;
        logic [6:0] entry_index;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] position;
        logic [7:0] out_char;
        logic       last_out;
        logic [7:0] word_count;
    } t_out_beat;

endpackage
`default_nettype wire

@@ hw/rtl/swt_ram.sv @@
// Simple dual-port synchronous RAM with one write and one registered read port.
// Holds the word rows and the pending word; depends on nothing.
`default_nettype none
module swt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/sorted_unique_word_table_core.sv @@
// Sorted unique word table: control sequencer, row RAM and pending-word RAM.
// A word end runs a binary search of at most ceil(log2(ENTRIES+1)) probes, each comparing the
// probed row with the pending word character by character; an insert then shifts the rows above
// the insert point up one at a time and writes the new row. A read emits one beat per character.
// One item is in work at a time. Reset clears the state, the output valid flag, the word count
// and the pending length only; the RAMs are not cleared and need no clearing pass.
`default_nettype none
module sorted_unique_word_table_core #(
    parameter int ENTRIES    = swt_pkg::ENTRIES_DEF,
    parameter int WORD_CHARS = swt_pkg::WORD_CHARS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire swt_pkg::t_in_beat i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output swt_pkg::t_out_beat     o_out_data,
    input  wire logic              i_out_stall
);

    import swt_pkg::*;

    localparam int EW = $clog2(ENTRIES);
    localparam int NW = $clog2(ENTRIES + 1);
    localparam int CW = $clog2(WORD_CHARS);
    localparam int LW = $clog2(WORD_CHARS + 1);
    localparam int RW = WORD_CHARS * 8 + LW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MID   = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_SHW   = 7'b0001000,
        S_INS   = 7'b0010000,
        S_RDOUT = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [NW-1:0] r_count, n_count, r_lo, n_lo, r_hi, n_hi;
    logic [EW-1:0] r_mid, n_mid, r_j, n_j;
    logic [LW-1:0] r_plen, n_plen, r_len, n_len, r_i, n_i;
    logic [WORD_CHARS-1:0][7:0] r_row, n_row;
    logic [6:0] r_idx, n_idx, r_pos, n_pos;
    logic [2:0] r_status, n_status;
    logic       r_ov;
    t_out_beat  r_od, out_beat;
    logic       out_load;

    // RAM ports.
    logic          st_rd_en, st_wr_en, pd_rd_en, pd_wr_en;
    logic [EW-1:0] st_rd_addr, st_wr_addr;
    logic [RW-1:0] st_rd_data, st_wr_data;
    logic [CW-1:0] pd_rd_addr, pd_wr_addr;
    logic [7:0]    pd_rd_data, pd_wr_data;

    swt_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_rows (
        .i_clk     (i_clk),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data)
    );

    swt_ram #(.WIDTH(8), .DEPTH(WORD_CHARS)) u_pend (
        .i_clk     (i_clk),
        .i_rd_en   (pd_rd_en),
        .i_rd_addr (pd_rd_addr),
        .o_rd_data (pd_rd_data),
        .i_wr_en   (pd_wr_en),
        .i_wr_addr (pd_wr_addr),
        .i_wr_data (pd_wr_data)
    );

    // Fields of the row just read.
    logic [WORD_CHARS-1:0][7:0] st_bytes;
    logic [LW-1:0] alen, cmp_n;
    logic [7:0]    st_byte, folded;
    logic [NW:0]   mid_sum;
    logic [LW-1:0] plen_new;
    logic          in_acc, out_free;
    logic [31:0]   mid_ext, lo_ext, cnt_ext;

    assign st_bytes = st_rd_data[WORD_CHARS*8-1:0];
    assign alen     = st_rd_data[RW-1 -: LW];
    assign cmp_n    = (alen < r_len) ? alen : r_len;
    assign st_byte  = st_bytes[r_i[CW-1:0]];
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_ext  = 32'(r_mid);
    assign lo_ext   = 32'(r_lo);
    assign cnt_ext  = 32'(r_count);
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Case folding of the incoming byte.
    always_comb begin
        folded = i_in_data.char_code;
        if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
            folded = folded + CASE_OFFSET;
        end
    end

    // Sequencer: collect, search, shift, insert, read back and emit the result beat.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_j      = r_j;
        n_plen   = r_plen;
        n_len    = r_len;
        n_i      = r_i;
        n_row    = r_row;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_status = r_status;
        plen_new = r_plen;
        st_rd_en   = 1'b0;
        st_rd_addr = r_mid;
        st_wr_en   = 1'b0;
        st_wr_addr = r_lo[EW-1:0];
        st_wr_data = st_rd_data;
        pd_rd_en   = 1'b0;
        pd_rd_addr = '0;
        pd_wr_en   = 1'b0;
        pd_wr_addr = r_plen[CW-1:0];
        pd_wr_data = folded;
        out_load   = 1'b0;
        out_beat   = '{status: r_status, position: r_pos, out_char: 8'd0,
                       last_out: 1'b1, word_count: cnt_ext[7:0]};
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.operation == OP_READ) begin
                    n_idx = i_in_data.entry_index;
                    if (32'(i_in_data.entry_index) >= cnt_ext) begin
                        n_status = ST_BADIDX;
                        n_pos    = i_in_data.entry_index;
                        n_state  = S_EMIT;
                    end else begin
                        st_rd_en   = 1'b1;
                        st_rd_addr = EW'(i_in_data.entry_index);
                        n_i        = '0;
                        n_state    = S_RDOUT;
                    end
                end else if (in_acc) begin
                    if (r_plen < LW'(WORD_CHARS)) begin
                        pd_wr_en = 1'b1;
                        n_row[r_plen[CW-1:0]] = folded;
                        plen_new = r_plen + 1'b1;
                    end
                    n_plen = plen_new;
                    if (i_in_data.last_char) begin
                        n_plen = '0;
                        n_len  = plen_new;
                        if (r_plen == '0 && folded == CHAR_PERIOD) begin
                            n_status = ST_PERIOD;
                            n_pos    = '0;
                            n_state  = S_EMIT;
                        end else begin
                            n_lo    = '0;
                            n_hi    = r_count;
                            n_state = S_MID;
                        end
                    end
                end
            end
            S_MID: begin
                if (r_lo < r_hi) begin
                    n_mid      = mid_sum[EW:1];
                    st_rd_en   = 1'b1;
                    st_rd_addr = mid_sum[EW:1];
                    pd_rd_en   = 1'b1;
                    n_i        = '0;
                    n_state    = S_CMP;
                end else if (r_count >= NW'(ENTRIES)) begin
                    n_status = ST_FULL;
                    n_pos    = '0;
                    n_state  = S_EMIT;
                end else if (r_count == r_lo) begin
                    n_state = S_INS;
                end else begin
                    n_j        = EW'(r_count - 1'b1);
                    st_rd_en   = 1'b1;
                    st_rd_addr = EW'(r_count - 1'b1);
                    n_state    = S_SHW;
                end
            end
            S_CMP: begin
                // One character of the probed row against the pending word per cycle.
                if (r_i == cmp_n) begin
                    if (alen == r_len) begin
                        n_status = ST_PRESENT;
                        n_pos    = mid_ext[6:0];
                        n_state  = S_EMIT;
                    end else if (alen < r_len) begin
                        n_lo    = NW'(r_mid) + 1'b1;
                        n_state = S_MID;
                    end else begin
                        n_hi    = NW'(r_mid);
                        n_state = S_MID;
                    end
                end else if (st_byte != pd_rd_data) begin
                    if (st_byte < pd_rd_data) begin
                        n_lo = NW'(r_mid) + 1'b1;
                    end else begin
                        n_hi = NW'(r_mid);
                    end
                    n_state = S_MID;
                end else begin
                    n_i        = r_i + 1'b1;
                    pd_rd_en   = 1'b1;
                    pd_rd_addr = CW'(r_i + 1'b1);
                end
            end
            S_SHW: begin
                // Move row j up one place and fetch the row below it.
                st_wr_en   = 1'b1;
                st_wr_addr = r_j + 1'b1;
                st_wr_data = st_rd_data;
                if (NW'(r_j) == r_lo) begin
                    n_state = S_INS;
                end else begin
                    n_j        = r_j - 1'b1;
                    st_rd_en   = 1'b1;
                    st_rd_addr = r_j - 1'b1;
                end
            end
            S_INS: begin
                st_wr_en   = 1'b1;
                st_wr_addr = r_lo[EW-1:0];
                st_wr_data = {r_len, r_row};
                n_count    = r_count + 1'b1;
                n_status   = ST_INSERTED;
                n_pos      = lo_ext[6:0];
                n_state    = S_EMIT;
            end
            S_RDOUT: begin
                out_beat = '{status: ST_READ, position: r_idx, out_char: st_byte,
                             last_out: (LW'(r_i + 1'b1) == alen), word_count: cnt_ext[7:0]};
                if (out_free) begin
                    out_load = 1'b1;
                    if (LW'(r_i + 1'b1) == alen) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_plen  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_plen  <= n_plen;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_j      <= n_j;
        r_len    <= n_len;
        r_i      <= n_i;
        r_row    <= n_row;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_status <= n_status;
        if (out_load) begin
            r_od <= out_beat;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule
`default_nettype wire
